// ----- design/aabb_3d_iou_gate_assert.svh -----
// Assertion macros shared by the IoU gate RTL.
`ifndef AABB_3D_IOU_GATE_ASSERT_SVH
`define AABB_3D_IOU_GATE_ASSERT_SVH

// Checked at every rising edge of aclk while aresetn is high.
`define AIOU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every rising edge of aclk, reset cycles included.
`define AIOU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/aiou_pkg.sv -----
// Shared widths, constants and request types of the 3D box IoU gate.
package aiou_pkg;

    // Field widths of one request.
    localparam int CTR_W = 16;
    localparam int EXT_W = 11;

    // Packing of the input tdata, first field in the lowest bits.
    localparam int TRK_C_LSB = 0;
    localparam int TRK_E_LSB = 3 * CTR_W;
    localparam int DET_C_LSB = TRK_E_LSB + 3 * EXT_W;
    localparam int DET_E_LSB = DET_C_LSB + 3 * CTR_W;
    localparam int S_TDATA_W = 168;

    // Datapath widths: doubled overlap, pair product, volume, union, dividend.
    localparam int OVL_W  = EXT_W + 1;
    localparam int PAIR_W = 2 * OVL_W;
    localparam int VOL_W  = 3 * OVL_W;
    localparam int UNI_W  = VOL_W + 1;
    localparam int FRAC_W = 16;
    localparam int NUM_W  = VOL_W + FRAC_W + 1;
    localparam int Q_W    = FRAC_W + 1;

    // The divider retires one quotient bit per stage.
    localparam int DIV_STAGES = Q_W;

    // Output tdata packing.
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - 2 * Q_W;

    localparam logic [Q_W-1:0]   ONE_Q16        = 17'd65536;
    localparam logic [Q_W-1:0]   THRESH_RESET   = 17'd6554;
    localparam logic [UNI_W-1:0] SMALL_UNION_X8 = 37'd800;

    // Configuration port: one register, word addressed.
    localparam int   CFG_ADDR_W        = 3;
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    // Divide request: rounded dividend, union as divisor, small-union flag.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [UNI_W-1:0] den;
        logic             union_small;
    } div_req_t;

    // Divide response.
    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic           union_small;
    } div_rsp_t;

endpackage

// ----- design/aabb_3d_iou_gate.sv -----
// Top level of the axis-aligned 3D box IoU gate with its configuration port.
// Each request is one track/detection box pair; the block returns IoU in Q16, the cost
// 65536 - IoU and a blocked flag (IoU below iou_threshold, register 0 at byte address 0,
// reset 6554). A pair is accepted every cycle while the result side does not stall, and
// its result is presented on m_tdata after it passes seven stages of overlap, volume and
// union arithmetic, seventeen divider stages that each retire one quotient bit, and the
// output register, 25 registers in all. Stalls on the result side hold the pipe, and empty
// stages close up so input is still taken while a result waits.
`include "aabb_3d_iou_gate_assert.svh"

module aabb_3d_iou_gate #(
    parameter int COORD_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pair requests.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // track_x, track_y, track_z, track_len, track_wid, track_hgt,
    // det_x, det_y, det_z, det_len, det_wid, det_hgt, zero fill
    input  logic [aiou_pkg::S_TDATA_W-1:0]    s_tdata,
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // iou_frac, match_cost, zero fill
    output logic [aiou_pkg::M_TDATA_W-1:0]    m_tdata,
    // blocked
    output logic                              m_tuser,
    // Configuration.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aiou_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int EW           = COORD_BITS + 2;
    localparam int FRONT_STAGES = 7;

    typedef logic signed [EW-1:0] bound_t;

    // Doubled center, sign-extended from the low COORD_BITS bits.
    function automatic bound_t dbl_center(input logic [aiou_pkg::CTR_W-1:0] raw);
        logic signed [COORD_BITS-1:0] c;
        c = COORD_BITS'(raw);
        return bound_t'(c) + bound_t'(c);
    endfunction

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [aiou_pkg::Q_W-1:0] thr_reg;
    logic                     cfg_idx;

    assign cfg_idx = paddr[aiou_pkg::CFG_ADDR_W-1];
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == aiou_pkg::REG_IOU_THRESHOLD) ? 32'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= aiou_pkg::THRESH_RESET;
        end else if (psel && penable && pwrite && pready
                     && cfg_idx == aiou_pkg::REG_IOU_THRESHOLD) begin
            thr_reg <= pwdata[aiou_pkg::Q_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Front pipeline flow control: a stage loads when empty or moving on.
    // ------------------------------------------------------------------
    logic [FRONT_STAGES-1:0] fv_reg;
    logic [FRONT_STAGES:0]   fadv;
    logic                    div_in_ready;

    assign fadv[FRONT_STAGES] = div_in_ready;
    for (genvar k = 0; k < FRONT_STAGES; k++) begin : g_fadv
        assign fadv[k] = !fv_reg[k] || fadv[k+1];
    end
    assign s_tready = fadv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else begin
            if (fadv[0]) begin
                fv_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (fadv[k]) begin
                    fv_reg[k] <= fv_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: doubled box edges per axis.
    // ------------------------------------------------------------------
    bound_t                     lo1_next [3];
    bound_t                     hi1_next [3];
    bound_t                     lo2_next [3];
    bound_t                     hi2_next [3];
    bound_t                     lo1_reg  [3];
    bound_t                     hi1_reg  [3];
    bound_t                     lo2_reg  [3];
    bound_t                     hi2_reg  [3];
    logic [aiou_pkg::EXT_W-1:0] ext1_reg [3];
    logic [aiou_pkg::EXT_W-1:0] ext2_reg [3];

    always_comb begin
        bound_t                     tc2;
        bound_t                     dc2;
        logic [aiou_pkg::OVL_W-1:0] te;
        logic [aiou_pkg::OVL_W-1:0] de;
        for (int a = 0; a < 3; a++) begin
            tc2 = dbl_center(s_tdata[aiou_pkg::TRK_C_LSB + aiou_pkg::CTR_W*a +: aiou_pkg::CTR_W]);
            dc2 = dbl_center(s_tdata[aiou_pkg::DET_C_LSB + aiou_pkg::CTR_W*a +: aiou_pkg::CTR_W]);
            te  = {1'b0, s_tdata[aiou_pkg::TRK_E_LSB + aiou_pkg::EXT_W*a +: aiou_pkg::EXT_W]};
            de  = {1'b0, s_tdata[aiou_pkg::DET_E_LSB + aiou_pkg::EXT_W*a +: aiou_pkg::EXT_W]};
            lo1_next[a] = tc2 - bound_t'(te);
            hi1_next[a] = tc2 + bound_t'(te);
            lo2_next[a] = dc2 - bound_t'(de);
            hi2_next[a] = dc2 + bound_t'(de);
        end
    end

    always_ff @(posedge aclk) begin
        if (fadv[0]) begin
            for (int a = 0; a < 3; a++) begin
                lo1_reg[a]  <= lo1_next[a];
                hi1_reg[a]  <= hi1_next[a];
                lo2_reg[a]  <= lo2_next[a];
                hi2_reg[a]  <= hi2_next[a];
                ext1_reg[a] <= s_tdata[aiou_pkg::TRK_E_LSB + aiou_pkg::EXT_W*a +: aiou_pkg::EXT_W];
                ext2_reg[a] <= s_tdata[aiou_pkg::DET_E_LSB + aiou_pkg::EXT_W*a +: aiou_pkg::EXT_W];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: inner edges per axis, first volume products.
    // ------------------------------------------------------------------
    bound_t                      hi_reg [3];
    bound_t                      lo_reg [3];
    logic [aiou_pkg::PAIR_W-1:0] p1_reg;
    logic [aiou_pkg::PAIR_W-1:0] p2_reg;
    logic [aiou_pkg::OVL_W-1:0]  h1d_reg;
    logic [aiou_pkg::OVL_W-1:0]  h2d_reg;

    always_ff @(posedge aclk) begin
        if (fadv[1]) begin
            for (int a = 0; a < 3; a++) begin
                hi_reg[a] <= (hi1_reg[a] < hi2_reg[a]) ? hi1_reg[a] : hi2_reg[a];
                lo_reg[a] <= (lo1_reg[a] > lo2_reg[a]) ? lo1_reg[a] : lo2_reg[a];
            end
            p1_reg  <= aiou_pkg::PAIR_W'({ext1_reg[0], 1'b0})
                     * aiou_pkg::PAIR_W'({ext1_reg[1], 1'b0});
            p2_reg  <= aiou_pkg::PAIR_W'({ext2_reg[0], 1'b0})
                     * aiou_pkg::PAIR_W'({ext2_reg[1], 1'b0});
            h1d_reg <= {ext1_reg[2], 1'b0};
            h2d_reg <= {ext2_reg[2], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: clamped overlaps; box volumes in doubled units.
    // The overlap never exceeds twice an extent, so it fits OVL_W bits.
    // ------------------------------------------------------------------
    logic [aiou_pkg::OVL_W-1:0] ov_next [3];
    logic [aiou_pkg::OVL_W-1:0] ov_reg  [3];
    logic [aiou_pkg::VOL_W-1:0] v1_reg;
    logic [aiou_pkg::VOL_W-1:0] v2_reg;

    always_comb begin
        bound_t diff;
        for (int a = 0; a < 3; a++) begin
            diff       = hi_reg[a] - lo_reg[a];
            ov_next[a] = (hi_reg[a] > lo_reg[a]) ? aiou_pkg::OVL_W'(diff) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fadv[2]) begin
            for (int a = 0; a < 3; a++) begin
                ov_reg[a] <= ov_next[a];
            end
            v1_reg <= aiou_pkg::VOL_W'(p1_reg) * aiou_pkg::VOL_W'(h1d_reg);
            v2_reg <= aiou_pkg::VOL_W'(p2_reg) * aiou_pkg::VOL_W'(h2d_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: x-y overlap area, volume sum.
    // ------------------------------------------------------------------
    logic [aiou_pkg::PAIR_W-1:0] oxy_reg;
    logic [aiou_pkg::OVL_W-1:0]  oz_reg;
    logic [aiou_pkg::UNI_W-1:0]  vsum4_reg;

    always_ff @(posedge aclk) begin
        if (fadv[3]) begin
            oxy_reg   <= aiou_pkg::PAIR_W'(ov_reg[0]) * aiou_pkg::PAIR_W'(ov_reg[1]);
            oz_reg    <= ov_reg[2];
            vsum4_reg <= aiou_pkg::UNI_W'(v1_reg) + aiou_pkg::UNI_W'(v2_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: intersection volume.
    // ------------------------------------------------------------------
    logic [aiou_pkg::VOL_W-1:0] inter5_reg;
    logic [aiou_pkg::UNI_W-1:0] vsum5_reg;

    always_ff @(posedge aclk) begin
        if (fadv[4]) begin
            inter5_reg <= aiou_pkg::VOL_W'(oxy_reg) * aiou_pkg::VOL_W'(oz_reg);
            vsum5_reg  <= vsum4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: union volume; the intersection is never above either volume.
    // ------------------------------------------------------------------
    logic [aiou_pkg::VOL_W-1:0] inter6_reg;
    logic [aiou_pkg::UNI_W-1:0] uni_reg;

    always_ff @(posedge aclk) begin
        if (fadv[5]) begin
            inter6_reg <= inter5_reg;
            uni_reg    <= vsum5_reg - aiou_pkg::UNI_W'(inter5_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: rounded dividend and small-union check.
    // ------------------------------------------------------------------
    aiou_pkg::div_req_t req_reg;

    always_ff @(posedge aclk) begin
        if (fadv[6]) begin
            req_reg.num         <= aiou_pkg::NUM_W'({inter6_reg, {aiou_pkg::FRAC_W{1'b0}}})
                                 + aiou_pkg::NUM_W'(uni_reg >> 1);
            req_reg.den         <= uni_reg;
            req_reg.union_small <= (uni_reg <= aiou_pkg::SMALL_UNION_X8);
        end
    end

    // ------------------------------------------------------------------
    // Divider.
    // ------------------------------------------------------------------
    logic               div_out_valid;
    logic               div_out_ready;
    aiou_pkg::div_rsp_t div_rsp;

    aiou_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fv_reg[FRONT_STAGES-1]),
        .in_ready  (div_in_ready),
        .in_req    (req_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Output register: saturated IoU, cost and gate flag.
    // ------------------------------------------------------------------
    logic                     m_tvalid_reg;
    logic [aiou_pkg::Q_W-1:0] iou_next;
    logic [aiou_pkg::Q_W-1:0] iou_reg;
    logic [aiou_pkg::Q_W-1:0] cost_reg;
    logic                     blocked_reg;
    logic                     cost_sum_ok;

    assign div_out_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        if (div_rsp.union_small) begin
            iou_next = '0;
        end else if (div_rsp.quot > aiou_pkg::ONE_Q16) begin
            iou_next = aiou_pkg::ONE_Q16;
        end else begin
            iou_next = div_rsp.quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (div_out_ready) begin
            m_tvalid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_out_ready) begin
            iou_reg     <= iou_next;
            cost_reg    <= aiou_pkg::ONE_Q16 - iou_next;
            blocked_reg <= (iou_next < thr_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{aiou_pkg::M_PAD_W{1'b0}}, cost_reg, iou_reg};
    assign m_tuser  = blocked_reg;

    // Sum of IoU and cost, one bit wider so that no wrap can hide an error.
    assign cost_sum_ok = ({1'b0, iou_reg} + {1'b0, cost_reg}) == {1'b0, aiou_pkg::ONE_Q16};

    // An empty output register means the whole pipe can move, so input is taken.
    `AIOU_ASSERT(a_top_ready_when_empty, !m_tvalid_reg |-> s_tready, "input stalled with empty output")
    // IoU and cost always add up to one.
    `AIOU_ASSERT(a_top_cost_sum, m_tvalid_reg |-> cost_sum_ok, "cost and IoU disagree")
    // IoU is saturated at one.
    `AIOU_ASSERT(a_top_iou_max, m_tvalid_reg |-> (iou_reg <= aiou_pkg::ONE_Q16), "IoU above one")
    // Reset empties the output register.
    `AIOU_ASSERT_ALWAYS(a_top_reset_clears, !aresetn |=> !m_tvalid_reg, "result left valid after reset")

endmodule

// ----- design/aiou_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`include "aabb_3d_iou_gate_assert.svh"

module aiou_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  aiou_pkg::div_req_t  in_req,
    output logic                out_valid,
    input  logic                out_ready,
    output aiou_pkg::div_rsp_t  out_rsp
);

    typedef struct packed {
        logic [aiou_pkg::UNI_W-1:0] rem;
        logic [aiou_pkg::Q_W-1:0]   quot;
        logic [aiou_pkg::Q_W-1:0]   low;
        logic [aiou_pkg::UNI_W-1:0] den;
        logic                       union_small;
    } step_t;

    // One shift-compare-subtract step; the next dividend bit comes from low.
    function automatic step_t div_step(input step_t cur);
        step_t                    nxt;
        logic [aiou_pkg::UNI_W:0] trial;
        logic [aiou_pkg::UNI_W:0] dext;
        logic                     take;
        nxt   = cur;
        trial = {cur.rem, cur.low[aiou_pkg::Q_W-1]};
        dext  = {1'b0, cur.den};
        take  = (trial >= dext);
        nxt.rem  = take ? aiou_pkg::UNI_W'(trial - dext) : aiou_pkg::UNI_W'(trial);
        nxt.quot = {cur.quot[aiou_pkg::Q_W-2:0], take};
        nxt.low  = {cur.low[aiou_pkg::Q_W-2:0], 1'b0};
        return nxt;
    endfunction

    step_t                          stage_reg  [aiou_pkg::DIV_STAGES];
    step_t                          stage_next [aiou_pkg::DIV_STAGES];
    step_t                          stage_in   [aiou_pkg::DIV_STAGES];
    logic [aiou_pkg::DIV_STAGES-1:0] valid_reg;
    logic [aiou_pkg::DIV_STAGES-1:0] src_valid;
    logic [aiou_pkg::DIV_STAGES:0]   load;
    step_t                          init;

    // The upper dividend bits start as the partial remainder; they stay below the divisor.
    always_comb begin
        init.rem         = aiou_pkg::UNI_W'(in_req.num[aiou_pkg::NUM_W-1:aiou_pkg::Q_W]);
        init.low         = in_req.num[aiou_pkg::Q_W-1:0];
        init.quot        = '0;
        init.den         = in_req.den;
        init.union_small = in_req.union_small;
    end

    // A stage loads when it is empty or its content moves on.
    assign load[aiou_pkg::DIV_STAGES] = out_ready;
    assign in_ready                   = load[0];

    for (genvar k = 0; k < aiou_pkg::DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign stage_in[k]  = init;
            assign src_valid[k] = in_valid;
        end else begin : g_rest
            assign stage_in[k]  = stage_reg[k-1];
            assign src_valid[k] = valid_reg[k-1];
        end

        assign load[k]       = !valid_reg[k] || load[k+1];
        assign stage_next[k] = div_step(stage_in[k]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (load[k]) begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (load[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Result of the last stage.
    assign out_valid           = valid_reg[aiou_pkg::DIV_STAGES-1];
    assign out_rsp.quot        = stage_reg[aiou_pkg::DIV_STAGES-1].quot;
    assign out_rsp.union_small = stage_reg[aiou_pkg::DIV_STAGES-1].union_small;

    // A full pipe with a stalled output must not take another request.
    `AIOU_ASSERT(a_div_full_stall, ((&valid_reg) && !out_ready) |-> !in_ready, "divider accepted while full")
    // The remainder stays below the union for every real division.
    `AIOU_ASSERT(a_div_rem_bound, (out_valid && !out_rsp.union_small) |-> (stage_reg[aiou_pkg::DIV_STAGES-1].rem < stage_reg[aiou_pkg::DIV_STAGES-1].den), "divider remainder out of range")
    // The intersection never exceeds the union, so the ratio is at most one.
    `AIOU_ASSERT(a_div_quot_max, (out_valid && !out_rsp.union_small) |-> (out_rsp.quot <= aiou_pkg::ONE_Q16), "divider quotient above one")

endmodule
